### rtl/core/rws_pkg.sv
// Package for the roulette wheel selector: field widths, command codes,
// the token that walks the cell chain, the result beat and the controller states.
// Depends on nothing; every other file in rtl/core uses it by scoped names.
package rws_pkg;

  localparam int CMD_W  = 2;
  localparam int FIT_W  = 32;
  localparam int SPIN_W = 17;
  localparam int FRAC_W = 16;
  localparam int IDX_W  = 6;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SPIN  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Token handed from cell to cell during a spin. The above flag tells the next
  // cell whether the target lies above the previous cumulative sum.
  typedef struct packed {
    logic             valid;
    logic             above;
    logic             found;
    logic [IDX_W-1:0] idx;
  } rws_token_t;

  typedef struct packed {
    logic [IDX_W-1:0] selected_index;
    logic             overflow;
  } rws_result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_SCAN
  } rws_state_t;

endpackage

### rtl/core/rws_item_if.sv
// Input channel of the roulette wheel selector: valid/ready plus the item fields.
// Depends on rws_pkg for the field widths.
interface rws_item_if;
  logic                        valid;
  logic                        ready;
  logic [rws_pkg::CMD_W-1:0]   command;
  logic [rws_pkg::FIT_W-1:0]   fitness;
  logic [rws_pkg::SPIN_W-1:0]  spin;

  modport source (output valid, command, fitness, spin, input ready);
  modport sink   (input valid, command, fitness, spin, output ready);
endinterface

### rtl/core/rws_result_if.sv
// Output channel of the roulette wheel selector: valid/ready plus the result fields.
// Depends on rws_pkg for the field widths.
interface rws_result_if;
  logic                       valid;
  logic                       ready;
  logic [rws_pkg::IDX_W-1:0]  selected_index;
  logic                       overflow;

  modport source (output valid, selected_index, overflow, input ready);
  modport sink   (input valid, selected_index, overflow, output ready);
endinterface

### rtl/core/rws_mult.sv
// Two-stage multiplier that scales the running total by the spin fraction.
// Depends on rws_pkg; the total is split in two halves so each product stays narrow.
module rws_mult #(
  parameter int SUM_W = 38,
  parameter int TGT_W = 55
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rws_pkg::SPIN_W-1:0] spin,
  input  logic [SUM_W-1:0]           total,
  output logic [TGT_W-1:0]           target,
  output logic                       done
);

  localparam int LO_W = SUM_W / 2;
  localparam int HI_W = SUM_W - LO_W;

  logic [rws_pkg::SPIN_W+LO_W-1:0] pp_lo;
  logic [rws_pkg::SPIN_W+HI_W-1:0] pp_hi;
  logic                            pp_valid;

  always_ff @(posedge clk) begin
    if (start) begin
      pp_lo <= (rws_pkg::SPIN_W+LO_W)'(spin) * (rws_pkg::SPIN_W+LO_W)'(total[LO_W-1:0]);
      pp_hi <= (rws_pkg::SPIN_W+HI_W)'(spin) * (rws_pkg::SPIN_W+HI_W)'(total[SUM_W-1:LO_W]);
    end
    if (pp_valid) begin
      target <= (TGT_W'(pp_hi) << LO_W) + TGT_W'(pp_lo);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      pp_valid <= start;
      done     <= pp_valid;
    end
  end

endmodule

### rtl/core/rws_cell.sv
// One cell of the wheel: holds one cumulative sum and checks a passing spin token.
// Depends on rws_pkg for the token type and field widths.
module rws_cell #(
  parameter int INDEX = 0,
  parameter int SUM_W = 38,
  parameter int CNT_W = 7,
  parameter int TGT_W = 55
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                we,
  input  logic [SUM_W-1:0]    wdata,
  input  logic [CNT_W-1:0]    count,
  input  logic [TGT_W-1:0]    target,
  input  rws_pkg::rws_token_t tok_in,
  output rws_pkg::rws_token_t tok_out
);

  logic [SUM_W-1:0]          cum;
  logic [TGT_W-1:0]          cum_scaled;
  logic                      le;
  logic                      in_use;
  logic                      match;
  logic                      tok_valid;
  logic                      tok_above;
  logic                      tok_found;
  logic [rws_pkg::IDX_W-1:0] tok_idx;

  always_ff @(posedge clk) begin
    if (we) begin
      cum <= wdata;
    end
  end

  assign cum_scaled = TGT_W'({cum, {rws_pkg::FRAC_W{1'b0}}});
  assign le         = target <= cum_scaled;
  assign in_use     = CNT_W'(INDEX) < count;
  // The lower bound comes from the previous cell as the above flag.
  assign match      = (INDEX != 0) && in_use && tok_in.above && le;

  always_ff @(posedge clk) begin
    tok_above <= ~le;
    tok_found <= tok_in.found | match;
    if (match && !tok_in.found) begin
      tok_idx <= rws_pkg::IDX_W'(INDEX);
    end else begin
      tok_idx <= tok_in.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  assign tok_out = '{valid: tok_valid, above: tok_above, found: tok_found, idx: tok_idx};

endmodule

### rtl/core/roulette_wheel_selector.sv
// Roulette wheel selector, top level: load, clear and spin control, the cell chain
// and a two-beat result queue. Depends on rws_pkg, rws_item_if, rws_result_if,
// rws_mult and rws_cell.
//
// Usage: each input beat carries a command. A load appends a fitness value and
// returns one result beat (overflow set when the table was full and the value was
// dropped). A clear empties the table and returns nothing. A spin returns one beat
// whose selected_index is the entry whose slice of the wheel holds spin * total,
// or 0 when no entry matches. Command code 3 is taken and ignored.
// Flow: loads and clears are taken back to back while the queue has room. A spin
// passes through the multiplier, then its token walks the chain of MAX_ENTRIES
// cells, registered at each cell. item.ready stays low during a spin.
// Reset clears the entry count, the running total and the result queue; the
// stored sums are not cleared, since only entries below the count are read.
// When the receiver stalls, up to two result beats wait in the queue; item.ready
// drops when the queue is full, and also during a spin.
module roulette_wheel_selector #(
  parameter int MAX_ENTRIES = 64
) (
  input  logic           clk,
  input  logic           rst,
  rws_item_if.sink       item,
  rws_result_if.source   result
);

  localparam int SUM_W = rws_pkg::FIT_W + $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int TGT_W = SUM_W + rws_pkg::SPIN_W;

  rws_pkg::rws_state_t  state;
  rws_pkg::rws_state_t  state_next;
  logic [CNT_W-1:0]     entry_count;
  logic [SUM_W-1:0]     running_total;
  logic [SUM_W-1:0]     load_sum;
  logic                 item_fire;
  logic                 load_fire;
  logic                 table_full;
  logic [TGT_W-1:0]     target;
  logic                 target_valid;
  rws_pkg::rws_token_t  tok [MAX_ENTRIES+1];
  logic                 chain_done;

  rws_pkg::rws_result_t fifo_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fifo_cnt;
  logic                 push;
  logic                 pop;
  rws_pkg::rws_result_t push_data;

  assign item_fire  = item.valid && item.ready;
  assign load_fire  = item_fire && (item.command == rws_pkg::CMD_LOAD);
  assign table_full = entry_count == CNT_W'(MAX_ENTRIES);
  assign load_sum   = running_total + SUM_W'(item.fitness);
  assign chain_done = tok[MAX_ENTRIES].valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      running_total <= '0;
    end else if (item_fire && item.command == rws_pkg::CMD_CLEAR) begin
      entry_count   <= '0;
      running_total <= '0;
    end else if (load_fire && !table_full) begin
      entry_count   <= entry_count + CNT_W'(1);
      running_total <= load_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rws_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      rws_pkg::ST_IDLE: begin
        if (item_fire && item.command == rws_pkg::CMD_SPIN) begin
          state_next = rws_pkg::ST_MULT;
        end
      end
      rws_pkg::ST_MULT: begin
        if (target_valid) begin
          state_next = rws_pkg::ST_SCAN;
        end
      end
      rws_pkg::ST_SCAN: begin
        if (chain_done) begin
          state_next = rws_pkg::ST_IDLE;
        end
      end
      default: state_next = rws_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item.ready = (state == rws_pkg::ST_IDLE) && (fifo_cnt != 2'd2);
  end

  rws_mult #(
    .SUM_W (SUM_W),
    .TGT_W (TGT_W)
  ) u_mult (
    .clk    (clk),
    .rst    (rst),
    .start  (item_fire && item.command == rws_pkg::CMD_SPIN),
    .spin   (item.spin),
    .total  (running_total),
    .target (target),
    .done   (target_valid)
  );

  assign tok[0] = '{valid: target_valid, above: 1'b0, found: 1'b0, idx: '0};

  for (genvar j = 0; j < MAX_ENTRIES; j++) begin : g_cell
    rws_cell #(
      .INDEX (j),
      .SUM_W (SUM_W),
      .CNT_W (CNT_W),
      .TGT_W (TGT_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .we      (load_fire && (entry_count == CNT_W'(j))),
      .wdata   (load_sum),
      .count   (entry_count),
      .target  (target),
      .tok_in  (tok[j]),
      .tok_out (tok[j+1])
    );
  end

  // A load reports at once; a spin reports when its token leaves the last cell.
  assign push = load_fire || chain_done;
  assign pop  = result.valid && result.ready;

  always_comb begin
    if (load_fire) begin
      push_data = '{selected_index: '0, overflow: table_full};
    end else begin
      push_data = '{selected_index: tok[MAX_ENTRIES].idx, overflow: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fifo_cnt <= fifo_cnt + 2'd1;
      end else if (pop && !push) begin
        fifo_cnt <= fifo_cnt - 2'd1;
      end
    end
  end

  assign result.valid          = fifo_cnt != 2'd0;
  assign result.selected_index = fifo_mem[rd_ptr].selected_index;
  assign result.overflow       = fifo_mem[rd_ptr].overflow;

endmodule

### rtl/core/rws_checker.sv
// Port-level checks for the roulette wheel selector, bound to the top level.
// Depends on rws_pkg for the command codes and field widths.
module rws_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       item_valid,
  input logic                       item_ready,
  input logic [rws_pkg::CMD_W-1:0]  item_command,
  input logic                       result_valid,
  input logic                       result_ready,
  input logic [rws_pkg::IDX_W-1:0]  selected_index,
  input logic                       overflow
);

  // Only a load can flag a drop, and a load's beat always carries index zero.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(overflow && selected_index != '0))
    else $error("overflow beat carries a nonzero index");

  // A spin holds off further input while the wheel is scanned.
  assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item_command == rws_pkg::CMD_SPIN) |=> !item_ready)
    else $error("input taken right after a spin");

  // The result queue is empty right after a reset cycle.
  assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat present right after reset");

  // A stalled result beat keeps its payload.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=>
      (result_valid && $stable(selected_index) && $stable(overflow)))
    else $error("stalled result beat changed");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
  .clk            (clk),
  .rst            (rst),
  .item_valid     (item.valid),
  .item_ready     (item.ready),
  .item_command   (item.command),
  .result_valid   (result.valid),
  .result_ready   (result.ready),
  .selected_index (result.selected_index),
  .overflow       (result.overflow)
);
